>>> hw/rtl/assert_macros.svh
// Assertion macros used by bppr_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> hw/rtl/bppr_pkg.sv
`default_nettype none
package bppr_pkg;
  localparam logic [2:0] OP_PIN     = 3'd0;
  localparam logic [2:0] OP_UNPIN   = 3'd1;
  localparam logic [2:0] OP_DIRTY   = 3'd2;
  localparam logic [2:0] OP_FORCE   = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;
  localparam logic [2:0] OP_INSPECT = 3'd5;

  localparam logic [2:0] MODE_FIFO  = 3'd0;
  localparam logic [2:0] MODE_LRU   = 3'd1;
  localparam logic [2:0] MODE_LFU   = 3'd2;
  localparam logic [2:0] MODE_LRU2  = 3'd3;
  localparam logic [2:0] MODE_CLOCK = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_NOVICT = 2'd2;

  localparam int REG_MODE   = 0;
  localparam int REG_FRAMES = 1;

  // controller to datapath
  typedef struct packed {
    logic start;   // load op, clear scan state
    logic scan;    // visit one frame
    logic commit;  // apply the op after the scan
    logic emit;    // load result register
    logic last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic flush_hit;   // current frame is valid and dirty
    logic flush_more;  // a dirty frame lies past the current one
    logic is_flush;
  } stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/bppr_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module bppr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic            out_busy,
  input  wire bppr_pkg::stat_t stat,
  output bppr_pkg::cmd_t       cmd,
  output logic                 idle
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state, state_next;

  // sequencer: frame a cycle; flush emits as it goes or stalls
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!(stat.is_flush && stat.flush_hit && out_busy)) begin
          cmd.scan = 1'b1;
          if (stat.is_flush && stat.flush_hit) begin
            // the final dirty frame closes the flush
            cmd.emit = 1'b1;
            cmd.last = !stat.flush_more;
            if (!stat.flush_more) state_next = S_IDLE;
            else if (stat.scan_done) state_next = S_DONE;
          end else if (stat.scan_done) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

  `ASSERT_IMPL(a_start_idle, clk, rst, cmd.start |-> state == S_IDLE)
  `ASSERT_IMPL(a_no_emit_busy, clk, rst, cmd.emit |-> !out_busy)
  `ASSERT_IMPL(a_commit_ret, clk, rst, cmd.commit |=> state == S_IDLE)
endmodule
`default_nettype wire

>>> hw/rtl/bppr_datapath.sv
`default_nettype none
module bppr_datapath #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 24,
  parameter int STAMP_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bppr_pkg::cmd_t        cmd,
  output bppr_pkg::stat_t            stat,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_idx,
  input  wire logic [4:0]            cfg_data,
  input  wire logic [2:0]            in_op,
  input  wire logic [PAGE_BITS-1:0]  in_page,
  input  wire logic [3:0]            in_fidx,
  output logic [1:0]                 r_status,
  output logic [3:0]                 r_frame,
  output logic                       r_fetch,
  output logic [22:0]                r_fetch_page,
  output logic                       r_wb,
  output logic [22:0]                r_wb_page,
  output logic [23:0]                r_slot_page,
  output logic                       r_slot_dirty,
  output logic [15:0]                r_slot_pins,
  output logic [31:0]                r_reads,
  output logic [31:0]                r_writes,
  output logic                       r_last
);
  localparam int FB = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CAP = (NUM_FRAMES < 16) ? NUM_FRAMES : 16;
  localparam logic [STAMP_BITS-1:0] SMAX = '1;

  logic [2:0] mode;
  logic [4:0] fiu;
  logic [PAGE_BITS-1:0]  pg [NUM_FRAMES];
  logic                  vld [NUM_FRAMES];
  logic                  drt [NUM_FRAMES];
  logic [15:0]           pins [NUM_FRAMES];
  logic [STAMP_BITS-1:0] lds [NUM_FRAMES];
  logic [STAMP_BITS-1:0] uss [NUM_FRAMES];
  logic [31:0]           ucn [NUM_FRAMES];
  logic [STAMP_BITS-1:0] ods [NUM_FRAMES];
  logic [STAMP_BITS-1:0] nws [NUM_FRAMES];
  logic [1:0]            hl  [NUM_FRAMES];
  logic [FB-1:0] hand;
  logic [STAMP_BITS-1:0] tick;
  logic [31:0] reads, writes;

  // latched op
  logic [2:0] op;
  logic [PAGE_BITS-1:0] page;
  logic [3:0] fidx;
  logic [4:0] n;
  logic [FB:0] cnt;
  logic [FB-1:0] idx;
  logic hit, emp, vic, cvic;
  logic [FB-1:0] hit_f, emp_f, vic_f, cvic_f;
  logic [31:0] vic_v;

  logic [FB-1:0] start_f;
  logic [FB-1:0] ci, ci_next;
  logic [4:0] nn;
  logic [31:0] key;
  logic more;

  assign nn = (fiu == 5'd0) ? 5'd1 : (fiu > 5'(CAP)) ? 5'(CAP) : fiu;
  assign idx = cnt[FB-1:0];
  assign stat.is_flush = (op == bppr_pkg::OP_FLUSH);
  assign stat.flush_hit = vld[idx] && drt[idx];
  assign stat.scan_done = (cnt + 1'b1) >= (FB+1)'(n);
  assign stat.flush_more = more;

  // any dirty frame left in use beyond the current one
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < NUM_FRAMES; j++)
      if (j > int'(idx) && j < int'(n) && vld[j] && drt[j]) more = 1'b1;
  end

  // clock scan index: start from hand, wrap at n
  always_comb begin
    ci_next = ci + 1'b1;
    if (5'(ci_next) >= n) ci_next = '0;
  end

  always_comb begin
    unique case (mode)
      bppr_pkg::MODE_LRU:  key = 32'(uss[idx]);
      bppr_pkg::MODE_LFU:  key = ucn[idx];
      bppr_pkg::MODE_LRU2: key = (hl[idx] >= 2'd2) ? 32'(ods[idx]) : 32'd0;
      default:             key = 32'(lds[idx]);
    endcase
  end

  logic neg;
  assign neg = page[PAGE_BITS-1];
  assign start_f = (5'(hand) < nn) ? hand : '0;

  logic [STAMP_BITS-1:0] tk1;
  assign tk1 = (tick != SMAX) ? tick + 1'b1 : tick;
  logic [31:0] wr1, rd1;
  assign wr1 = (writes != '1) ? writes + 1 : writes;
  assign rd1 = (reads != '1) ? reads + 1 : reads;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bppr_pkg::MODE_FIFO;
      fiu <= 5'd16;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        vld[i] <= 1'b0; drt[i] <= 1'b0; pins[i] <= '0;
        lds[i] <= '0; uss[i] <= '0; ucn[i] <= '0;
        ods[i] <= '0; nws[i] <= '0; hl[i] <= '0;
      end
      hand <= '0; tick <= '0; reads <= '0; writes <= '0;
      r_last <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == 1'(bppr_pkg::REG_MODE)) mode <= cfg_data[2:0];
        else fiu <= cfg_data;
      end
      if (cmd.start) begin
        op <= in_op; page <= in_page; fidx <= in_fidx;
        n <= nn; cnt <= '0; ci <= start_f;
        hit <= 1'b0; emp <= 1'b0; vic <= 1'b0; cvic <= 1'b0;
        hit_f <= '0; emp_f <= '0; vic_f <= '0; cvic_f <= '0; vic_v <= '0;
      end
      if (cmd.scan) begin
        cnt <= cnt + 1'b1;
        ci <= ci_next;
        if (!hit && vld[idx] && pg[idx] == page) begin hit <= 1'b1; hit_f <= idx; end
        if (!emp && !vld[idx]) begin emp <= 1'b1; emp_f <= idx; end
        if (pins[idx] == 16'd0 && (!vic || key < vic_v)) begin
          vic <= 1'b1; vic_f <= idx; vic_v <= key;
        end
        if (!cvic && pins[ci] == 16'd0) begin cvic <= 1'b1; cvic_f <= ci; end
        if (stat.is_flush && stat.flush_hit) begin
          drt[idx] <= 1'b0; writes <= wr1;
        end
      end
      // results: zero defaults but last and totals, filled per op
      if (cmd.emit) begin
        r_status <= bppr_pkg::ST_OK; r_frame <= '0; r_fetch <= 1'b0;
        r_fetch_page <= '0; r_wb <= 1'b0; r_wb_page <= '0;
        r_slot_page <= '0; r_slot_dirty <= 1'b0; r_slot_pins <= '0;
        r_last <= cmd.last; r_reads <= reads; r_writes <= writes;
        if (stat.is_flush && stat.flush_hit && !cmd.commit) begin
          r_frame <= 4'(idx); r_wb <= 1'b1; r_wb_page <= 23'(pg[idx]);
          r_writes <= wr1;
        end
      end
      if (cmd.commit) begin
        if (op == bppr_pkg::OP_FLUSH) begin
          // no dirty frame: one empty result
        end else if (op == bppr_pkg::OP_INSPECT) begin
          if (32'(fidx) < NUM_FRAMES) begin
            r_frame <= fidx;
            r_slot_page <= vld[FB'(fidx)] ? 24'(signed'(pg[FB'(fidx)])) : '1;
            r_slot_dirty <= drt[FB'(fidx)];
            r_slot_pins <= pins[FB'(fidx)];
          end else begin
            r_status <= bppr_pkg::ST_BAD; r_slot_page <= '1;
          end
        end else if (op > bppr_pkg::OP_INSPECT || neg) begin
          r_status <= bppr_pkg::ST_BAD;
        end else if (op == bppr_pkg::OP_PIN) begin
          if (hit) begin
            r_frame <= 4'(hit_f);
            if (pins[hit_f] != '1) pins[hit_f] <= pins[hit_f] + 1'b1;
            tick <= tk1;
            if (mode == bppr_pkg::MODE_LRU) uss[hit_f] <= tk1;
            if (mode == bppr_pkg::MODE_LFU && ucn[hit_f] != '1)
              ucn[hit_f] <= ucn[hit_f] + 1;
            if (mode == bppr_pkg::MODE_LRU2) begin
              if (hl[hit_f] == 2'd0) begin ods[hit_f] <= tk1; hl[hit_f] <= 2'd1; end
              else if (hl[hit_f] == 2'd1) begin nws[hit_f] <= tk1; hl[hit_f] <= 2'd2; end
              else begin ods[hit_f] <= nws[hit_f]; nws[hit_f] <= tk1; end
            end
          end else if (!emp && !((mode == bppr_pkg::MODE_CLOCK) ? cvic : vic)) begin
            r_status <= bppr_pkg::ST_NOVICT;
          end else begin
            logic [FB-1:0] f;
            logic wbk;
            f = emp ? emp_f : (mode == bppr_pkg::MODE_CLOCK) ? cvic_f : vic_f;
            wbk = !emp && drt[f];
            if (!emp && mode == bppr_pkg::MODE_CLOCK)
              hand <= (5'(f) + 5'd1 >= n) ? '0 : f + 1'b1;
            if (wbk) begin
              r_wb <= 1'b1; r_wb_page <= 23'(pg[f]); writes <= wr1; r_writes <= wr1;
            end
            reads <= rd1; r_reads <= rd1; tick <= tk1;
            vld[f] <= 1'b1; pg[f] <= page; drt[f] <= 1'b0; pins[f] <= 16'd1;
            lds[f] <= tk1; uss[f] <= tk1; ucn[f] <= 32'd1; ods[f] <= tk1;
            nws[f] <= '0; hl[f] <= 2'd1;
            r_frame <= 4'(f); r_fetch <= 1'b1; r_fetch_page <= 23'(page);
          end
        end else if (!hit) begin
          r_status <= bppr_pkg::ST_BAD;
        end else begin
          r_frame <= 4'(hit_f);
          if (op == bppr_pkg::OP_UNPIN) begin
            if (pins[hit_f] != 16'd0) pins[hit_f] <= pins[hit_f] - 1'b1;
          end else if (op == bppr_pkg::OP_DIRTY) begin
            drt[hit_f] <= 1'b1;
          end else if (drt[hit_f]) begin
            drt[hit_f] <= 1'b0; writes <= wr1; r_writes <= wr1;
            r_wb <= 1'b1; r_wb_page <= 23'(page);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/buffer_pool_page_replacer.sv
`default_nettype none
// Buffer pool page-frame manager.
// Requests arrive on s_axis (op, page_number, frame_index); results leave on
// m_axis, one per request except flush, which gives one per dirty frame (one
// empty result if none), the final one marked by tlast. Replacement policy
// and frame count are written through cfg_we/cfg_idx/cfg_data; the user
// writes them only while the block is idle, which the block does not enforce.
// Each request scans the frames in use (frames_in_use held to 1..16, at most
// NUM_FRAMES) one per cycle unless a flush pauses; the op is then applied and
// its result loaded into the output register, a flush loading each result in
// the scan. A new request is taken only after the previous one has handed
// over its final result. A held result waits in the output register until
// m_axis_tready is high; a flush pauses its scan at a dirty frame while a
// result is held and ends at its last dirty frame. Reset empties all frames,
// clears counters, stamps and the clock hand; mode is fifo, frames_in_use 16.
module buffer_pool_page_replacer #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 24,
  parameter int STAMP_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[2:0], page_number[26:3], frame_index[30:27]
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0] frame[5:2] fetch[6] fetch_page[29:7] write_back[30]
  // write_back_page[53:31] slot_page[77:54] slot_dirty[78] slot_pins[94:79]
  // read_total[126:95] write_total[158:127]
  output logic [159:0]     m_axis_tdata,
  output logic             m_axis_tlast
);
  bppr_pkg::cmd_t  cmd;
  bppr_pkg::stat_t stat;
  logic idle, valid, in_fire;
  logic [1:0] st; logic [3:0] fr; logic fe, wb, sd, lst;
  logic [22:0] fp, wp; logic [23:0] sp; logic [15:0] pn; logic [31:0] rt, wt;

  assign s_axis_tready = idle && !valid;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  bppr_ctrl u_ctrl (.clk, .rst, .in_fire, .out_busy(valid && !m_axis_tready),
    .stat, .cmd, .idle);

  bppr_datapath #(.NUM_FRAMES(NUM_FRAMES), .PAGE_BITS(PAGE_BITS),
    .STAMP_BITS(STAMP_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_idx, .cfg_data,
    .in_op(s_axis_tdata[2:0]), .in_page(PAGE_BITS'(s_axis_tdata[26:3])),
    .in_fidx(s_axis_tdata[30:27]),
    .r_status(st), .r_frame(fr), .r_fetch(fe), .r_fetch_page(fp), .r_wb(wb),
    .r_wb_page(wp), .r_slot_page(sp), .r_slot_dirty(sd), .r_slot_pins(pn),
    .r_reads(rt), .r_writes(wt), .r_last(lst));

  // output valid
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (cmd.emit) valid <= 1'b1;
    else if (m_axis_tready) valid <= 1'b0;
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tlast = lst;
  assign m_axis_tdata = {1'b0, wt, rt, pn, sd, sp, wp, wb, fp, fe, fr, st};
endmodule
`default_nettype wire
